// File: sv/avn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package avn_pkg;

  // Field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned FRAC_W  = 8;

  // Offset is target + 8 - shooter; needs two more bits than a coordinate
  localparam int unsigned AIM_OFFSET = 8;
  localparam int unsigned DIFF_W     = COORD_W + 2;
  localparam int unsigned MAG_W      = DIFF_W - 1;

  // |offset| * |speed| stays below 2^32 for every input pattern
  localparam int unsigned PROD_W = 32;

  // |offset| <= length, so the quotient magnitude is at most |speed| * 256
  localparam int unsigned QUO_W           = SPD_W + FRAC_W;
  localparam int unsigned STEPS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // One divider lane: partial remainder, dividend bits still to shift in,
  // quotient bits gathered so far.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [SPD_W-1:0] low;
    logic [QUO_W-1:0] quo;
  } avn_lane_t;

  // Everything one item carries through the divider stages
  typedef struct packed {
    logic              active;
    logic              zero;
    logic              neg_x;
    logic              neg_y;
    logic [FRAC_W-1:0] spd_lo;
    logic [MAG_W-1:0]  len;
    avn_lane_t         lane_x;
    avn_lane_t         lane_y;
  } avn_pipe_t;

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor if it fits.
  function automatic avn_lane_t avn_div_step(avn_lane_t l, logic [MAG_W-1:0] d);
    logic [MAG_W:0] t;
    avn_lane_t      r;
    t     = {l.rem, l.low[SPD_W-1]};
    r.low = {l.low[SPD_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = MAG_W'(t - {1'b0, d});
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = t[MAG_W-1:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/avn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module avn_front (
  input  wire logic                              clk,
  input  wire logic                              en_a,
  input  wire logic                              en_b,
  input  wire logic                              shooter_active,
  input  wire logic signed [avn_pkg::COORD_W-1:0] shooter_x,
  input  wire logic signed [avn_pkg::COORD_W-1:0] shooter_y,
  input  wire logic signed [avn_pkg::COORD_W-1:0] target_x,
  input  wire logic signed [avn_pkg::COORD_W-1:0] target_y,
  input  wire logic signed [avn_pkg::SPD_W-1:0]   speed,
  output avn_pkg::avn_pipe_t                     d_out
);

  typedef struct packed {
    logic                       active;
    logic                       zero;
    logic                       sgn_x;
    logic                       sgn_y;
    logic                       sgn_s;
    logic [avn_pkg::FRAC_W-1:0] spd_lo;
    logic [avn_pkg::MAG_W-1:0]  ax;
    logic [avn_pkg::MAG_W-1:0]  ay;
    logic [avn_pkg::SPD_W-1:0]  sa;
    logic [avn_pkg::MAG_W-1:0]  len;
  } avn_geom_t;

  logic signed [avn_pkg::DIFF_W-1:0] dx;
  logic signed [avn_pkg::DIFF_W-1:0] dy;
  avn_geom_t                         a_nxt;
  avn_geom_t                         a_r;

  logic [avn_pkg::MAG_W+avn_pkg::SPD_W-1:0] px;
  logic [avn_pkg::MAG_W+avn_pkg::SPD_W-1:0] py;
  avn_pkg::avn_pipe_t                       b_nxt;
  avn_pkg::avn_pipe_t                       b_r;

  // Stage A: offsets, magnitudes, approximate length
  always_comb begin
    dx = avn_pkg::DIFF_W'(target_x) + avn_pkg::DIFF_W'(avn_pkg::AIM_OFFSET)
         - avn_pkg::DIFF_W'(shooter_x);
    dy = avn_pkg::DIFF_W'(target_y) + avn_pkg::DIFF_W'(avn_pkg::AIM_OFFSET)
         - avn_pkg::DIFF_W'(shooter_y);
    a_nxt.active = shooter_active;
    a_nxt.zero   = (dx == '0) && (dy == '0);
    a_nxt.sgn_x  = dx[avn_pkg::DIFF_W-1];
    a_nxt.sgn_y  = dy[avn_pkg::DIFF_W-1];
    a_nxt.sgn_s  = speed[avn_pkg::SPD_W-1];
    a_nxt.spd_lo = speed[avn_pkg::FRAC_W-1:0];
    a_nxt.ax     = dx[avn_pkg::DIFF_W-1] ? avn_pkg::MAG_W'(-dx) : dx[avn_pkg::MAG_W-1:0];
    a_nxt.ay     = dy[avn_pkg::DIFF_W-1] ? avn_pkg::MAG_W'(-dy) : dy[avn_pkg::MAG_W-1:0];
    a_nxt.sa     = speed[avn_pkg::SPD_W-1] ? avn_pkg::SPD_W'(-speed) : speed;
    if (a_nxt.ax > a_nxt.ay) begin
      a_nxt.len = a_nxt.ax + (a_nxt.ay >> 1);
    end else begin
      a_nxt.len = a_nxt.ay + (a_nxt.ax >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: magnitude products, seed the divider lanes
  always_comb begin
    px = a_r.ax * a_r.sa;
    py = a_r.ay * a_r.sa;
    b_nxt.active     = a_r.active;
    b_nxt.zero       = a_r.zero;
    b_nxt.neg_x      = a_r.sgn_x ^ a_r.sgn_s;
    b_nxt.neg_y      = a_r.sgn_y ^ a_r.sgn_s;
    b_nxt.spd_lo     = a_r.spd_lo;
    b_nxt.len        = a_r.len;
    b_nxt.lane_x.rem = avn_pkg::MAG_W'(px[avn_pkg::PROD_W-1:avn_pkg::SPD_W]);
    b_nxt.lane_x.low = px[avn_pkg::SPD_W-1:0];
    b_nxt.lane_x.quo = '0;
    b_nxt.lane_y.rem = avn_pkg::MAG_W'(py[avn_pkg::PROD_W-1:avn_pkg::SPD_W]);
    b_nxt.lane_y.low = py[avn_pkg::SPD_W-1:0];
    b_nxt.lane_y.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_r <= b_nxt;
    end
  end

  assign d_out = b_r;

endmodule

`default_nettype wire

// File: sv/avn_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module avn_div_stage (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire avn_pkg::avn_pipe_t d_in,
  output avn_pkg::avn_pipe_t      d_out
);

  avn_pkg::avn_lane_t lx;
  avn_pkg::avn_lane_t ly;
  avn_pkg::avn_pipe_t q_nxt;
  avn_pkg::avn_pipe_t q_r;

  // Advance both lanes by STEPS_PER_STAGE quotient bits
  always_comb begin
    lx = d_in.lane_x;
    ly = d_in.lane_y;
    for (int i = 0; i < avn_pkg::STEPS_PER_STAGE; i++) begin
      lx = avn_pkg::avn_div_step(lx, d_in.len);
      ly = avn_pkg::avn_div_step(ly, d_in.len);
    end
    q_nxt        = d_in;
    q_nxt.lane_x = lx;
    q_nxt.lane_y = ly;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

`default_nettype wire

// File: sv/aim_velocity_normalizer.sv
// Pipeline: offset/length stage, product stage, eight divider stages and
//   the output register.
// Throughput: one item per cycle unless every stage is full and the output
//   stalls; each divider stage resolves 3 quotient bits.
// Reset: synchronous, active low on rst_n; clears all valid bits, payload
//   registers keep whatever they hold.
`timescale 1ns / 1ps
`default_nettype none

module aim_velocity_normalizer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_shooter_active,
  input  wire logic signed [avn_pkg::COORD_W-1:0] in_shooter_x,
  input  wire logic signed [avn_pkg::COORD_W-1:0] in_shooter_y,
  input  wire logic signed [avn_pkg::COORD_W-1:0] in_target_x,
  input  wire logic signed [avn_pkg::COORD_W-1:0] in_target_y,
  input  wire logic signed [avn_pkg::SPD_W-1:0]   in_speed,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_fire,
  output logic signed [avn_pkg::SPD_W-1:0]        out_vel_x,
  output logic signed [avn_pkg::SPD_W-1:0]        out_vel_y
);

  // Stage 0 and 1 live in the front end, then the divider stages
  localparam int unsigned NUM_ST = avn_pkg::DIV_STAGES + 2;

  logic [NUM_ST-1:0]  v_r;
  logic [NUM_ST-1:0]  v_nxt;
  logic [NUM_ST:0]    ready;
  logic               out_valid_r;
  logic               out_fire_r;
  logic               out_fire_nxt;
  logic [avn_pkg::SPD_W-1:0] out_vel_x_r;
  logic [avn_pkg::SPD_W-1:0] out_vel_x_nxt;
  logic [avn_pkg::SPD_W-1:0] out_vel_y_r;
  logic [avn_pkg::SPD_W-1:0] out_vel_y_nxt;

  avn_pkg::avn_pipe_t pipe [avn_pkg::DIV_STAGES+1];
  avn_pkg::avn_pipe_t last;

  // A stage may load when it is empty or its content moves on this cycle.
  // Bubbles collapse, so the input keeps flowing while the output register
  // waits for its transfer until every stage is full.
  always_comb begin
    ready[NUM_ST] = !out_valid_r || !out_stall;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      ready[k] = !v_r[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[0];

  // Valid bits travel alongside the payload
  always_comb begin
    v_nxt[0] = ready[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_ST; k++) begin
      if (!ready[k]) begin
        v_nxt[k] = v_r[k];
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (ready[NUM_ST]) begin
        out_valid_r <= v_r[NUM_ST-1];
      end
    end
  end

  // Offsets, length and magnitude products
  avn_front u_front (
    .clk            (clk),
    .en_a           (ready[0]),
    .en_b           (ready[1]),
    .shooter_active (in_shooter_active),
    .shooter_x      (in_shooter_x),
    .shooter_y      (in_shooter_y),
    .target_x       (in_target_x),
    .target_y       (in_target_y),
    .speed          (in_speed),
    .d_out          (pipe[0])
  );

  // Restoring divider, both axes side by side
  for (genvar g = 0; g < avn_pkg::DIV_STAGES; g++) begin : g_div
    avn_div_stage u_div (
      .clk   (clk),
      .en    (ready[g+2]),
      .d_in  (pipe[g]),
      .d_out (pipe[g+1])
    );
  end

  assign last = pipe[avn_pkg::DIV_STAGES];

  // Apply signs and pick the special cases: an inactive shooter gives
  // nothing, a target straight on top fires along y at full speed.
  always_comb begin
    out_fire_nxt = last.active;
    if (!last.active) begin
      out_vel_x_nxt = '0;
      out_vel_y_nxt = '0;
    end else if (last.zero) begin
      out_vel_x_nxt = '0;
      out_vel_y_nxt = {last.spd_lo, {avn_pkg::FRAC_W{1'b0}}};
    end else begin
      out_vel_x_nxt = last.neg_x ? avn_pkg::SPD_W'(-last.lane_x.quo)
                                 : last.lane_x.quo[avn_pkg::SPD_W-1:0];
      out_vel_y_nxt = last.neg_y ? avn_pkg::SPD_W'(-last.lane_y.quo)
                                 : last.lane_y.quo[avn_pkg::SPD_W-1:0];
    end
  end

  // Output register: hold while the downstream side stalls
  always_ff @(posedge clk) begin
    if (ready[NUM_ST]) begin
      out_fire_r  <= out_fire_nxt;
      out_vel_x_r <= out_vel_x_nxt;
      out_vel_y_r <= out_vel_y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_fire  = out_fire_r;
  assign out_vel_x = out_vel_x_r;
  assign out_vel_y = out_vel_y_r;

  // The input only stalls with every stage full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // An accepted transfer always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted item lost at pipeline entry");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v_r[NUM_ST-1]) |=> !out_valid_r)
    else $error("result repeated after transfer");

  // No fire means zero velocity
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fire_r) |-> (out_vel_x_r == '0 && out_vel_y_r == '0))
    else $error("inactive shooter produced a velocity");

endmodule

`default_nettype wire

// File: dv/tb_aim_velocity_normalizer.sv
`timescale 1ns / 1ps

module tb_aim_velocity_normalizer;

  typedef logic signed [avn_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [avn_pkg::SPD_W-1:0]   speed_t;

  // One aim request as it crosses the input channel
  typedef struct {
    logic   active;
    coord_t sx;
    coord_t sy;
    coord_t tx;
    coord_t ty;
    speed_t spd;
  } aim_req_t;

  // One velocity result as it crosses the output channel
  typedef struct {
    logic   fire;
    speed_t vel_x;
    speed_t vel_y;
  } shot_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam longint      AIM_BIAS   = 8;    // target is aimed at its center, 8 px in
  localparam longint      FIX_SCALE  = 256;  // 8.8 fixed point
  localparam int          REPORT_MAX = 10;
  localparam int          RAND_ITEMS = 1380;
  localparam int          LONG_HOLD  = 300;
  localparam int          TAIL_WAIT  = 24;
  localparam int unsigned CYCLE_CAP  = 400000;

  // Holds the expected velocities in transfer order and checks each result
  class aim_scoreboard;
    shot_t       expected_shots[$];
    int unsigned faults;
    int unsigned results;
    int unsigned aims;
    int unsigned idle_aims;
    int unsigned on_top_aims;

    function shot_t aim_predict(aim_req_t r);
      shot_t  s;
      longint spd, dx, dy, ax, ay, len, qx, qy;
      s.fire  = 1'b0;
      s.vel_x = '0;
      s.vel_y = '0;
      if (!r.active) begin
        idle_aims++;
        return s;
      end
      s.fire = 1'b1;
      spd = longint'(r.spd);
      dx  = longint'(r.tx) + AIM_BIAS - longint'(r.sx);
      dy  = longint'(r.ty) + AIM_BIAS - longint'(r.sy);
      if (dx == 0 && dy == 0) begin
        on_top_aims++;
        qy      = spd * FIX_SCALE;
        s.vel_y = qy[15:0];
        return s;
      end
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      len = (ax > ay) ? ax + (ay >> 1) : ay + (ax >> 1);
      if (len <= 0) len = 1;
      // signed division truncates toward zero; keep the low 16 bits
      qx      = (dx * spd * FIX_SCALE) / len;
      qy      = (dy * spd * FIX_SCALE) / len;
      s.vel_x = qx[15:0];
      s.vel_y = qy[15:0];
      return s;
    endfunction

    function void note_aim(aim_req_t r);
      aims++;
      expected_shots.push_back(aim_predict(r));
    endfunction

    function void check_shot(shot_t got);
      shot_t want;
      results++;
      if (expected_shots.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("[%0t] result with nothing expected: fire=%0b vel_x=%0d vel_y=%0d",
                   $realtime, got.fire, got.vel_x, got.vel_y);
        return;
      end
      want = expected_shots.pop_front();
      if (got.fire !== want.fire || got.vel_x !== want.vel_x || got.vel_y !== want.vel_y) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display({"[%0t] result %0d: expected fire=%0b vel_x=%0d vel_y=%0d,",
                    " got fire=%0b vel_x=%0d vel_y=%0d"},
                   $realtime, results, want.fire, want.vel_x, want.vel_y,
                   got.fire, got.vel_x, got.vel_y);
      end
    endfunction

    function int unsigned pending();
      return expected_shots.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_shooter_active;
  coord_t in_shooter_x;
  coord_t in_shooter_y;
  coord_t in_target_x;
  coord_t in_target_y;
  speed_t in_speed;
  logic   out_valid;
  logic   out_stall;
  logic   out_fire;
  speed_t out_vel_x;
  speed_t out_vel_y;

  aim_scoreboard sb = new();

  // Set by the stimulus thread; the receiver picks it up and runs its long hold
  bit          long_hold_req;
  int unsigned long_holds;
  int unsigned in_stall_cycles;

  aim_velocity_normalizer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_shooter_active (in_shooter_active),
    .in_shooter_x      (in_shooter_x),
    .in_shooter_y      (in_shooter_y),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .in_speed          (in_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fire          (out_fire),
    .out_vel_x         (out_vel_x),
    .out_vel_y         (out_vel_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels. All drives are nonblocking, so the values read here are
  // the ones the block saw at this edge.
  always @(posedge clk) begin : watch_ports
    aim_req_t seen;
    shot_t    got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.active = in_shooter_active;
        seen.sx     = in_shooter_x;
        seen.sy     = in_shooter_y;
        seen.tx     = in_target_x;
        seen.ty     = in_target_y;
        seen.spd    = in_speed;
        sb.note_aim(seen);
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) begin
        got.fire  = out_fire;
        got.vel_x = out_vel_x;
        got.vel_y = out_vel_y;
        sb.check_shot(got);
      end
    end
  end

  // Receiver: switch between stall patterns at random intervals, and run a
  // long hold whenever the stimulus thread asks for one.
  initial begin : rx_pattern
    stall_mode_t mode;
    int          left;
    int unsigned phase;
    mode  = STALL_NONE;
    left  = 0;
    phase = 0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 160);
        end
        left--;
        phase++;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= ((phase % 5) < 2);
          default:        out_stall <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Cut the run short if the block hangs
  initial begin : watchdog
    repeat (CYCLE_CAP) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", CYCLE_CAP, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request and hold it until the transfer happens
  task automatic offer_aim(input aim_req_t r);
    in_valid          <= 1'b1;
    in_shooter_active <= r.active;
    in_shooter_x      <= r.sx;
    in_shooter_y      <= r.sy;
    in_target_x       <= r.tx;
    in_target_y       <= r.ty;
    in_speed          <= r.spd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic aim_at(input logic act, input int sx, input int sy,
                        input int tx, input int ty, input int spd);
    aim_req_t r;
    r.active = act;
    r.sx     = coord_t'(sx);
    r.sy     = coord_t'(sy);
    r.tx     = coord_t'(tx);
    r.ty     = coord_t'(ty);
    r.spd    = speed_t'(spd);
    offer_aim(r);
  endtask

  // Drop valid and idle until every expected result has come back. Wait on the
  // clock before the first check so the last transfer has been noted.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Random request: live shots near the target with small speeds, fully random
  // fields, inactive shooters and targets straight on top.
  function automatic aim_req_t rand_aim();
    aim_req_t    r;
    int unsigned pick;
    int          sgn;
    pick     = $urandom_range(0, 99);
    r.active = 1'b1;
    r.sx     = coord_t'($urandom);
    r.sy     = coord_t'($urandom);
    r.tx     = coord_t'($urandom);
    r.ty     = coord_t'($urandom);
    r.spd    = speed_t'($urandom);
    if (pick < 12) begin
      r.active = 1'b0;
    end else if (pick < 20) begin
      // keep target + 8 inside the coordinate range so the offset is exactly zero
      r.tx = coord_t'(int'($urandom_range(0, 65527)) - 32768);
      r.ty = coord_t'(int'($urandom_range(0, 65527)) - 32768);
      r.sx = coord_t'(int'(r.tx) + int'(AIM_BIAS));
      r.sy = coord_t'(int'(r.ty) + int'(AIM_BIAS));
    end else if (pick < 60) begin
      sgn  = $urandom_range(0, 1) ? -1 : 1;
      r.sx = coord_t'(int'($urandom_range(0, 4000)) - 2000);
      r.sy = coord_t'(int'($urandom_range(0, 4000)) - 2000);
      r.tx = coord_t'(int'(r.sx) - int'(AIM_BIAS) + int'($urandom_range(0, 600)) - 300);
      r.ty = coord_t'(int'(r.sy) - int'(AIM_BIAS) + int'($urandom_range(0, 600)) - 300);
      r.spd = speed_t'(sgn * int'($urandom_range(0, 16)));
    end
    return r;
  endfunction

  initial begin : stimulus
    int i;
    int burst_left;
    int gap;
    int rush;

    in_valid          <= 1'b0;
    in_shooter_active <= 1'b0;
    in_shooter_x      <= '0;
    in_shooter_y      <= '0;
    in_target_x       <= '0;
    in_target_y       <= '0;
    in_speed          <= '0;
    rst_n             <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Inactive shooter: no fire, zero velocity whatever the other fields hold
    aim_at(1'b0, 0, 0, 0, 0, 0);
    aim_at(1'b0, -32768, 32767, 32767, -32768, 32767);
    // Target straight on top: velocity is (0, speed << 8), wrapped
    aim_at(1'b1, 8, 8, 0, 0, 3);
    aim_at(1'b1, -32760, 32767, -32768, 32759, -32768);
    aim_at(1'b1, 32767, -32760, 32759, -32768, 32767);
    aim_at(1'b1, 8, 8, 0, 0, 128);
    aim_at(1'b0, 8, 8, 0, 0, 5);
    // Widest offsets on one axis, both speed extremes
    aim_at(1'b1, -32768, 8, 32767, 0, 32767);
    aim_at(1'b1, 32767, 8, -32768, 0, -32768);
    aim_at(1'b1, 8, -32768, 0, 32767, -32768);
    aim_at(1'b1, 8, 32767, 0, -32768, 32767);
    // Widest offsets on both axes
    aim_at(1'b1, -32768, -32768, 32767, 32767, 32767);
    aim_at(1'b1, 32767, 32767, -32768, -32768, -32768);
    aim_at(1'b1, -32768, 32767, 32767, -32768, 1);
    // Unit offset: quotient is speed * 256 and wraps past 16 bits
    aim_at(1'b1, 7, 8, 0, 0, 1);
    aim_at(1'b1, 7, 8, 0, 0, 127);
    aim_at(1'b1, 7, 8, 0, 0, 128);
    aim_at(1'b1, 8, 9, 0, 0, -1);
    aim_at(1'b1, 9, 7, 0, 0, 32767);
    // Diagonal, zero speed, negative speed pointing away from the target
    aim_at(1'b1, 3, 3, 0, 0, 4);
    aim_at(1'b1, 100, 50, 200, 60, 0);
    aim_at(1'b1, 100, 50, 200, 60, -6);
    aim_at(1'b1, 0, 0, 0, 0, -32768);
    wait_results();

    // Random traffic in bursts; two stretches run back to back against a long
    // receiver hold so the pipeline backs up, and one pause drains everything.
    burst_left = 0;
    rush       = 0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300 || i == 950) begin
        long_hold_req = 1'b1;
        rush          = 48;
      end
      if (i == 650) wait_results();
      if (rush > 0) begin
        rush--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left > 0) burst_left--;
      offer_aim(rand_aim());
    end
    wait_results();
    repeat (TAIL_WAIT) @(posedge clk);

    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    $display("covered %0d aim transfers: %0d inactive shooters, %0d targets straight on top",
             sb.aims, sb.idle_aims, sb.on_top_aims);
    $display("checked %0d results, %0d long receiver holds, input held off for %0d cycles",
             sb.results, long_holds, in_stall_cycles);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.faults);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
